// ----- rtl/core/ecp_pkg.sv -----
// shared widths and the per-pair payload type for the disc pair collision block
// no dependencies; used by every module under rtl/core
`default_nettype none
package ecp_pkg;

	localparam int DATA_W    = 32;
	localparam int MASS_W    = 16;
	localparam int RS_W      = 24;
	localparam int MAG_W     = 24;
	localparam int D2_W      = 48;
	localparam int ROOT_W    = 24;
	localparam int DOT_W     = 59;
	localparam int DOT_MAG_W = 58;
	localparam int DOT_LO_W  = 32;

	// push divider: overlap times offset over twice the distance
	localparam int PQ_NUM_W = 48;
	localparam int PQ_DEN_W = 25;
	// projection divider: dot times offset over squared distance
	localparam int VQ_NUM_W = 82;
	localparam int VQ_DEN_W = 48;
	localparam int VQ_Q_W   = 34;
	// mass weighting divider
	localparam int MQ_NUM_W = 52;
	localparam int MQ_DEN_W = 17;
	localparam int MQ_Q_W   = 35;

	typedef struct packed {
		logic              hit;
		logic              zero;
		logic [DATA_W-1:0] apx;
		logic [DATA_W-1:0] apy;
		logic [DATA_W-1:0] avx;
		logic [DATA_W-1:0] avy;
		logic [DATA_W-1:0] bpx;
		logic [DATA_W-1:0] bpy;
		logic [DATA_W-1:0] bvx;
		logic [DATA_W-1:0] bvy;
		logic [RS_W-1:0]   rs;
		logic [MASS_W-1:0] ma;
		logic [MASS_W-1:0] mb;
	} side_t;

endpackage
`default_nettype wire

// ----- rtl/core/ecp_div.sv -----
// pipelined restoring divider, one quotient bit per stage, rounded to nearest
// sign-magnitude in and out; widths default from ecp_pkg
`default_nettype none
module ecp_div #(
	parameter int NUM_W = ecp_pkg::VQ_NUM_W,
	parameter int DEN_W = ecp_pkg::VQ_DEN_W,
	parameter int Q_W   = ecp_pkg::VQ_Q_W
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic             neg,
	output logic      [Q_W:0]     quo_mag,
	output logic                  quo_neg
);

	logic [DEN_W-1:0]       rem_s  [Q_W];
	logic [Q_W-1:0]         work_s [Q_W];
	logic [DEN_W-1:0]       den_s  [Q_W];
	logic                   neg_s  [Q_W];
	logic [NUM_W+DEN_W-1:0] num_ext;
	logic                   round_up;

	assign num_ext = {{DEN_W{1'b0}}, num};

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_in;
		logic [Q_W-1:0]   work_in;
		logic [DEN_W-1:0] den_in;
		logic             neg_in;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   sub;
		logic             take;

		if (k == 0) begin : g_first
			assign rem_in  = num_ext[Q_W +: DEN_W];
			assign work_in = num[Q_W-1:0];
			assign den_in  = den;
			assign neg_in  = neg;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign work_in = work_s[k-1];
			assign den_in  = den_s[k-1];
			assign neg_in  = neg_s[k-1];
		end

		assign trial = {rem_in, work_in[Q_W-1]};
		assign sub   = trial - {1'b0, den_in};
		assign take  = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
				work_s[k] <= {work_in[Q_W-2:0], take};
				den_s[k]  <= den_in;
				neg_s[k]  <= neg_in;
			end
		end
	end

	// ties go away from zero: remainder at least half the divisor
	assign round_up = {rem_s[Q_W-1], 1'b0} >= {1'b0, den_s[Q_W-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			quo_mag <= {1'b0, work_s[Q_W-1]} + {{Q_W{1'b0}}, round_up};
			quo_neg <= neg_s[Q_W-1];
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/ecp_isqrt.sv -----
// pipelined integer square root, one root bit per stage, floor result
// width defaults from ecp_pkg
`default_nettype none
module ecp_isqrt #(
	parameter int ROOT_W = ecp_pkg::ROOT_W
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [2*ROOT_W-1:0] rad,
	output logic      [ROOT_W-1:0]   root
);

	logic [ROOT_W+1:0]   rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];
	logic [2*ROOT_W-1:0] work_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [ROOT_W+1:0]   rem_in;
		logic [ROOT_W-1:0]   root_in;
		logic [2*ROOT_W-1:0] work_in;
		logic [ROOT_W+3:0]   acc;
		logic [ROOT_W+3:0]   trial;
		logic [ROOT_W+3:0]   sub;
		logic                take;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign work_in = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign work_in = work_s[k-1];
		end

		// bring down the next bit pair, try 4*root+1
		assign acc   = {rem_in, work_in[2*ROOT_W-1 -: 2]};
		assign trial = {2'b00, root_in, 2'b01};
		assign sub   = acc - trial;
		assign take  = acc >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? sub[ROOT_W+1:0] : acc[ROOT_W+1:0];
				root_s[k] <= {root_in[ROOT_W-2:0], take};
				work_s[k] <= {work_in[2*ROOT_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule
`default_nettype wire

// ----- rtl/core/elastic_disc_pair_collision.sv -----
// elastic collision of one disc pair per accepted input word
// throughput one word per cycle; the whole pipeline advances together and holds on out_stall
// depth is set by the square root (24 stages) and two restoring dividers (35 and 36 stages)
// reset clears only the valid bits of every stage; payload registers are not reset
`default_nettype none
module elastic_disc_pair_collision (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] a_pos_x,
	input  wire logic [31:0] a_pos_y,
	input  wire logic [31:0] a_vel_x,
	input  wire logic [31:0] a_vel_y,
	input  wire logic [15:0] a_mass,
	input  wire logic [31:0] b_pos_x,
	input  wire logic [31:0] b_pos_y,
	input  wire logic [31:0] b_vel_x,
	input  wire logic [31:0] b_vel_y,
	input  wire logic [15:0] b_mass,
	input  wire logic [23:0] radius_sum,
	input  wire logic        both_enabled,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      a_new_pos_x,
	output logic [31:0]      a_new_pos_y,
	output logic [31:0]      a_new_vel_x,
	output logic [31:0]      a_new_vel_y,
	output logic [31:0]      b_new_pos_x,
	output logic [31:0]      b_new_pos_y,
	output logic [31:0]      b_new_vel_x,
	output logic [31:0]      b_new_vel_y,
	output logic             hit,
	output logic             saturated
);

	localparam int SQ_LAT = ecp_pkg::ROOT_W;
	localparam int DV_LAT = ecp_pkg::VQ_Q_W + 1;
	localparam int MS_LAT = ecp_pkg::MQ_Q_W + 1;
	localparam int MAG_W  = ecp_pkg::MAG_W;
	localparam int VQM_W  = ecp_pkg::VQ_Q_W + 1;
	localparam int MQM_W  = ecp_pkg::MQ_Q_W + 1;
	localparam logic signed [32:0] NEAR_HI = 33'sd16777216;
	localparam logic signed [32:0] NEAR_LO = -33'sd16777216;

	// bundle carried across the square root
	typedef struct packed {
		ecp_pkg::side_t                 side;
		logic [MAG_W-1:0]               adx;
		logic [MAG_W-1:0]               ady;
		logic                           sdx;
		logic                           sdy;
		logic [ecp_pkg::VQ_NUM_W-1:0]   numqx;
		logic [ecp_pkg::VQ_NUM_W-1:0]   numqy;
		logic                           negqx;
		logic                           negqy;
		logic [ecp_pkg::D2_W-1:0]       d2;
	} sq_t;

	// bundle carried across the mass dividers
	typedef struct packed {
		ecp_pkg::side_t side;
		logic [VQM_W-1:0] pxm;
		logic             pxn;
		logic [VQM_W-1:0] pym;
		logic             pyn;
	} ms_t;

	// whole pipeline moves while the output register is free or being taken
	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_sq [SQ_LAT];
	logic vld_dv [DV_LAT];
	logic vld_ms [MS_LAT];

	assign in_stall  = vld_s9 && out_stall;
	assign en        = !in_stall;
	assign out_valid = vld_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			for (int k = 0; k < SQ_LAT; k++) vld_sq[k] <= 1'b0;
			for (int k = 0; k < DV_LAT; k++) vld_dv[k] <= 1'b0;
			for (int k = 0; k < MS_LAT; k++) vld_ms[k] <= 1'b0;
		end else if (en) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_sq[0] <= vld_s6;
			for (int k = 1; k < SQ_LAT; k++) vld_sq[k] <= vld_sq[k-1];
			vld_s7    <= vld_sq[SQ_LAT-1];
			vld_dv[0] <= vld_s7;
			for (int k = 1; k < DV_LAT; k++) vld_dv[k] <= vld_dv[k-1];
			vld_s8    <= vld_dv[DV_LAT-1];
			vld_ms[0] <= vld_s8;
			for (int k = 1; k < MS_LAT; k++) vld_ms[k] <= vld_ms[k-1];
			vld_s9    <= vld_ms[MS_LAT-1];
		end
	end

	// stage 1: register the word, centre and velocity differences
	ecp_pkg::side_t     side_s1;
	logic signed [32:0] dx_s1, dy_s1, dvx_s1, dvy_s1;
	logic               live_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.hit  <= 1'b0;
			side_s1.zero <= 1'b0;
			side_s1.apx  <= a_pos_x;
			side_s1.apy  <= a_pos_y;
			side_s1.avx  <= a_vel_x;
			side_s1.avy  <= a_vel_y;
			side_s1.bpx  <= b_pos_x;
			side_s1.bpy  <= b_pos_y;
			side_s1.bvx  <= b_vel_x;
			side_s1.bvy  <= b_vel_y;
			side_s1.rs   <= radius_sum;
			side_s1.ma   <= a_mass;
			side_s1.mb   <= b_mass;
			live_s1      <= both_enabled;
			dx_s1  <= $signed({a_pos_x[31], a_pos_x}) - $signed({b_pos_x[31], b_pos_x});
			dy_s1  <= $signed({a_pos_y[31], a_pos_y}) - $signed({b_pos_y[31], b_pos_y});
			dvx_s1 <= $signed({a_vel_x[31], a_vel_x}) - $signed({b_vel_x[31], b_vel_x});
			dvy_s1 <= $signed({a_vel_y[31], a_vel_y}) - $signed({b_vel_y[31], b_vel_y});
		end
	end

	// stage 2: near test, squares, dot partial terms, offset magnitudes
	logic signed [24:0] dxn_c, dyn_c, dxa_c, dya_c;
	logic signed [49:0] dxsq_c, dysq_c;
	logic signed [57:0] pdx_c, pdy_c;
	logic [47:0]        rs2_c;

	assign dxn_c  = dx_s1[24:0];
	assign dyn_c  = dy_s1[24:0];
	assign dxsq_c = dxn_c * dxn_c;
	assign dysq_c = dyn_c * dyn_c;
	assign pdx_c  = dvx_s1 * dxn_c;
	assign pdy_c  = dvy_s1 * dyn_c;
	assign rs2_c  = side_s1.rs * side_s1.rs;
	assign dxa_c  = dxn_c[24] ? -dxn_c : dxn_c;
	assign dya_c  = dyn_c[24] ? -dyn_c : dyn_c;

	ecp_pkg::side_t     side_s2;
	logic               live_s2;
	logic [47:0]        dx2_s2, dy2_s2, rs2_s2;
	logic signed [57:0] pdx_s2, pdy_s2;
	logic [MAG_W-1:0]   adx_s2, ady_s2;
	logic               sdx_s2, sdy_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side_s1;
			live_s2 <= live_s1 && (dx_s1 > NEAR_LO) && (dx_s1 < NEAR_HI)
			           && (dy_s1 > NEAR_LO) && (dy_s1 < NEAR_HI);
			dx2_s2  <= dxsq_c[47:0];
			dy2_s2  <= dysq_c[47:0];
			rs2_s2  <= rs2_c;
			pdx_s2  <= pdx_c;
			pdy_s2  <= pdy_c;
			adx_s2  <= dxa_c[MAG_W-1:0];
			ady_s2  <= dya_c[MAG_W-1:0];
			sdx_s2  <= dxn_c[24];
			sdy_s2  <= dyn_c[24];
		end
	end

	// stage 3: squared distance, exact hit compare, dot product
	logic [48:0] d2_c;
	assign d2_c = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	// side bundle with the hit and coincidence flags filled in
	ecp_pkg::side_t side_c;

	always_comb begin
		side_c      = side_s2;
		side_c.hit  = live_s2 && (d2_c < {1'b0, rs2_s2});
		side_c.zero = d2_c == '0;
	end

	ecp_pkg::side_t     side_s3;
	logic [47:0]        d2_s3;
	logic signed [58:0] dot_s3;
	logic [MAG_W-1:0]   adx_s3, ady_s3;
	logic               sdx_s3, sdy_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3      <= side_c;
			d2_s3        <= d2_c[47:0];
			dot_s3       <= $signed({pdx_s2[57], pdx_s2}) + $signed({pdy_s2[57], pdy_s2});
			adx_s3       <= adx_s2;
			ady_s3       <= ady_s2;
			sdx_s3       <= sdx_s2;
			sdy_s3       <= sdy_s2;
		end
	end

	// stage 4: dot magnitude and projection signs
	logic signed [58:0] dota_c;
	assign dota_c = dot_s3[58] ? -dot_s3 : dot_s3;

	ecp_pkg::side_t                  side_s4;
	logic [47:0]                     d2_s4;
	logic [ecp_pkg::DOT_MAG_W-1:0]   dotm_s4;
	logic [MAG_W-1:0]                adx_s4, ady_s4;
	logic                            sdx_s4, sdy_s4, negqx_s4, negqy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4  <= side_s3;
			d2_s4    <= d2_s3;
			dotm_s4  <= dota_c[ecp_pkg::DOT_MAG_W-1:0];
			adx_s4   <= adx_s3;
			ady_s4   <= ady_s3;
			sdx_s4   <= sdx_s3;
			sdy_s4   <= sdy_s3;
			negqx_s4 <= dot_s3[58] ^ sdx_s3;
			negqy_s4 <= dot_s3[58] ^ sdy_s3;
		end
	end

	// stage 5: dot times offset, split in two partial products
	ecp_pkg::side_t   side_s5;
	logic [47:0]      d2_s5;
	logic [55:0]      plox_s5, ploy_s5;
	logic [49:0]      phix_s5, phiy_s5;
	logic [MAG_W-1:0] adx_s5, ady_s5;
	logic             sdx_s5, sdy_s5, negqx_s5, negqy_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5  <= side_s4;
			d2_s5    <= d2_s4;
			plox_s5  <= dotm_s4[ecp_pkg::DOT_LO_W-1:0] * adx_s4;
			ploy_s5  <= dotm_s4[ecp_pkg::DOT_LO_W-1:0] * ady_s4;
			phix_s5  <= dotm_s4[ecp_pkg::DOT_MAG_W-1:ecp_pkg::DOT_LO_W] * adx_s4;
			phiy_s5  <= dotm_s4[ecp_pkg::DOT_MAG_W-1:ecp_pkg::DOT_LO_W] * ady_s4;
			adx_s5   <= adx_s4;
			ady_s5   <= ady_s4;
			sdx_s5   <= sdx_s4;
			sdy_s5   <= sdy_s4;
			negqx_s5 <= negqx_s4;
			negqy_s5 <= negqy_s4;
		end
	end

	// stage 6: combine partial products, feed the square root
	sq_t sq_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s6.side  <= side_s5;
			sq_s6.d2    <= d2_s5;
			sq_s6.numqx <= {phix_s5, 32'b0} + {26'b0, plox_s5};
			sq_s6.numqy <= {phiy_s5, 32'b0} + {26'b0, ploy_s5};
			sq_s6.adx   <= adx_s5;
			sq_s6.ady   <= ady_s5;
			sq_s6.sdx   <= sdx_s5;
			sq_s6.sdy   <= sdy_s5;
			sq_s6.negqx <= negqx_s5;
			sq_s6.negqy <= negqy_s5;
		end
	end

	logic [ecp_pkg::ROOT_W-1:0] root;
	sq_t sq_line [SQ_LAT];

	ecp_isqrt #(
		.ROOT_W (ecp_pkg::ROOT_W)
	) u_isqrt (
		.clk  (clk),
		.en   (en),
		.rad  (sq_s6.d2),
		.root (root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sq_line[0] <= sq_s6;
			for (int k = 1; k < SQ_LAT; k++) sq_line[k] <= sq_line[k-1];
		end
	end

	// stage 7: overlap and push numerators
	sq_t        sq_end;
	logic [23:0] diff_c;
	assign sq_end = sq_line[SQ_LAT-1];
	assign diff_c = sq_end.side.rs - root;

	ecp_pkg::side_t               side_s7;
	logic [ecp_pkg::PQ_NUM_W-1:0] numpx_s7, numpy_s7;
	logic [ecp_pkg::PQ_DEN_W-1:0] denp_s7;
	logic [ecp_pkg::VQ_NUM_W-1:0] numqx_s7, numqy_s7;
	logic [47:0]                  d2_s7;
	logic                         sdx_s7, sdy_s7, negqx_s7, negqy_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7  <= sq_end.side;
			numpx_s7 <= diff_c * sq_end.adx;
			numpy_s7 <= diff_c * sq_end.ady;
			denp_s7  <= {root, 1'b0};
			numqx_s7 <= sq_end.numqx;
			numqy_s7 <= sq_end.numqy;
			d2_s7    <= sq_end.d2;
			sdx_s7   <= sq_end.sdx;
			sdy_s7   <= sq_end.sdy;
			negqx_s7 <= sq_end.negqx;
			negqy_s7 <= sq_end.negqy;
		end
	end

	// push and projection dividers share one latency
	logic [VQM_W-1:0] pxm, pym, qxm, qym;
	logic             pxn, pyn, qxn, qyn;

	ecp_div #(
		.NUM_W (ecp_pkg::PQ_NUM_W),
		.DEN_W (ecp_pkg::PQ_DEN_W),
		.Q_W   (ecp_pkg::VQ_Q_W)
	) u_div_px (
		.clk (clk), .en (en), .num (numpx_s7), .den (denp_s7), .neg (sdx_s7),
		.quo_mag (pxm), .quo_neg (pxn)
	);

	ecp_div #(
		.NUM_W (ecp_pkg::PQ_NUM_W),
		.DEN_W (ecp_pkg::PQ_DEN_W),
		.Q_W   (ecp_pkg::VQ_Q_W)
	) u_div_py (
		.clk (clk), .en (en), .num (numpy_s7), .den (denp_s7), .neg (sdy_s7),
		.quo_mag (pym), .quo_neg (pyn)
	);

	ecp_div #(
		.NUM_W (ecp_pkg::VQ_NUM_W),
		.DEN_W (ecp_pkg::VQ_DEN_W),
		.Q_W   (ecp_pkg::VQ_Q_W)
	) u_div_qx (
		.clk (clk), .en (en), .num (numqx_s7), .den (d2_s7), .neg (negqx_s7),
		.quo_mag (qxm), .quo_neg (qxn)
	);

	ecp_div #(
		.NUM_W (ecp_pkg::VQ_NUM_W),
		.DEN_W (ecp_pkg::VQ_DEN_W),
		.Q_W   (ecp_pkg::VQ_Q_W)
	) u_div_qy (
		.clk (clk), .en (en), .num (numqy_s7), .den (d2_s7), .neg (negqy_s7),
		.quo_mag (qym), .quo_neg (qyn)
	);

	ecp_pkg::side_t dv_line [DV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_line[0] <= side_s7;
			for (int k = 1; k < DV_LAT; k++) dv_line[k] <= dv_line[k-1];
		end
	end

	// stage 8: mass weighting numerators; both masses zero act as equal masses
	ecp_pkg::side_t dv_end;
	logic [15:0]    m1_c, m2_c;
	assign dv_end = dv_line[DV_LAT-1];
	assign m1_c   = (dv_end.ma == '0 && dv_end.mb == '0) ? 16'd1 : dv_end.ma;
	assign m2_c   = (dv_end.ma == '0 && dv_end.mb == '0) ? 16'd1 : dv_end.mb;

	ms_t                          ms_s8;
	logic [ecp_pkg::MQ_NUM_W-1:0] nax_s8, nay_s8, nbx_s8, nby_s8;
	logic [ecp_pkg::MQ_DEN_W-1:0] msum_s8;
	logic                         qxn_s8, qyn_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			ms_s8.side <= dv_end;
			ms_s8.pxm  <= pxm;
			ms_s8.pxn  <= pxn;
			ms_s8.pym  <= pym;
			ms_s8.pyn  <= pyn;
			nax_s8     <= qxm * {m2_c, 1'b0};
			nay_s8     <= qym * {m2_c, 1'b0};
			nbx_s8     <= qxm * {m1_c, 1'b0};
			nby_s8     <= qym * {m1_c, 1'b0};
			msum_s8    <= {1'b0, m1_c} + {1'b0, m2_c};
			qxn_s8     <= qxn;
			qyn_s8     <= qyn;
		end
	end

	logic [MQM_W-1:0] vaxm, vaym, vbxm, vbym;
	logic             vaxn, vayn, vbxn, vbyn;

	ecp_div #(
		.NUM_W (ecp_pkg::MQ_NUM_W),
		.DEN_W (ecp_pkg::MQ_DEN_W),
		.Q_W   (ecp_pkg::MQ_Q_W)
	) u_div_vax (
		.clk (clk), .en (en), .num (nax_s8), .den (msum_s8), .neg (qxn_s8),
		.quo_mag (vaxm), .quo_neg (vaxn)
	);

	ecp_div #(
		.NUM_W (ecp_pkg::MQ_NUM_W),
		.DEN_W (ecp_pkg::MQ_DEN_W),
		.Q_W   (ecp_pkg::MQ_Q_W)
	) u_div_vay (
		.clk (clk), .en (en), .num (nay_s8), .den (msum_s8), .neg (qyn_s8),
		.quo_mag (vaym), .quo_neg (vayn)
	);

	ecp_div #(
		.NUM_W (ecp_pkg::MQ_NUM_W),
		.DEN_W (ecp_pkg::MQ_DEN_W),
		.Q_W   (ecp_pkg::MQ_Q_W)
	) u_div_vbx (
		.clk (clk), .en (en), .num (nbx_s8), .den (msum_s8), .neg (qxn_s8),
		.quo_mag (vbxm), .quo_neg (vbxn)
	);

	ecp_div #(
		.NUM_W (ecp_pkg::MQ_NUM_W),
		.DEN_W (ecp_pkg::MQ_DEN_W),
		.Q_W   (ecp_pkg::MQ_Q_W)
	) u_div_vby (
		.clk (clk), .en (en), .num (nby_s8), .den (msum_s8), .neg (qyn_s8),
		.quo_mag (vbym), .quo_neg (vbyn)
	);

	ms_t ms_line [MS_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			ms_line[0] <= ms_s8;
			for (int k = 1; k < MS_LAT; k++) ms_line[k] <= ms_line[k-1];
		end
	end

	// stage 9: apply updates, clip to 32 bits, select pass-through on no hit, x-only push on coincident centres
	function automatic logic signed [39:0] add_mag(input logic [31:0] base,
	                                               input logic [MQM_W-1:0] mag,
	                                               input logic sub);
		logic signed [39:0] b;
		logic signed [39:0] m;
		b = $signed({{8{base[31]}}, base});
		m = $signed({{(40-MQM_W){1'b0}}, mag});
		return sub ? b - m : b + m;
	endfunction

	function automatic logic over32(input logic signed [39:0] v);
		return (v > 40'sd2147483647) || (v < -40'sd2147483648);
	endfunction

	function automatic logic [31:0] clip32(input logic signed [39:0] v);
		logic [31:0] r;
		if (v > 40'sd2147483647) r = 32'h7fff_ffff;
		else if (v < -40'sd2147483648) r = 32'h8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	ms_t              ms_end;
	logic [23:0]      half_c;
	logic [MQM_W-1:0] half_m;
	logic signed [39:0] wapx, wapy, wavx, wavy, wbpx, wbpy, wbvx, wbvy, zapx, zbpx;

	assign ms_end = ms_line[MS_LAT-1];
	assign half_c = 24'(({1'b0, ms_end.side.rs} + 25'd1) >> 1);
	assign half_m = {{(MQM_W-24){1'b0}}, half_c};

	assign wapx = add_mag(ms_end.side.apx, {1'b0, ms_end.pxm}, ms_end.pxn);
	assign wapy = add_mag(ms_end.side.apy, {1'b0, ms_end.pym}, ms_end.pyn);
	assign wbpx = add_mag(ms_end.side.bpx, {1'b0, ms_end.pxm}, !ms_end.pxn);
	assign wbpy = add_mag(ms_end.side.bpy, {1'b0, ms_end.pym}, !ms_end.pyn);
	assign wavx = add_mag(ms_end.side.avx, vaxm, !vaxn);
	assign wavy = add_mag(ms_end.side.avy, vaym, !vayn);
	assign wbvx = add_mag(ms_end.side.bvx, vbxm, vbxn);
	assign wbvy = add_mag(ms_end.side.bvy, vbym, vbyn);
	// coincident centres: push along x only, velocities untouched
	assign zapx = add_mag(ms_end.side.apx, half_m, 1'b0);
	assign zbpx = add_mag(ms_end.side.bpx, half_m, 1'b1);

	always_ff @(posedge clk) begin
		if (en) begin
			hit <= ms_end.side.hit;
			priority if (!ms_end.side.hit) begin
				a_new_pos_x <= ms_end.side.apx;
				a_new_pos_y <= ms_end.side.apy;
				a_new_vel_x <= ms_end.side.avx;
				a_new_vel_y <= ms_end.side.avy;
				b_new_pos_x <= ms_end.side.bpx;
				b_new_pos_y <= ms_end.side.bpy;
				b_new_vel_x <= ms_end.side.bvx;
				b_new_vel_y <= ms_end.side.bvy;
				saturated   <= 1'b0;
			end else if (ms_end.side.zero) begin
				a_new_pos_x <= clip32(zapx);
				a_new_pos_y <= ms_end.side.apy;
				a_new_vel_x <= ms_end.side.avx;
				a_new_vel_y <= ms_end.side.avy;
				b_new_pos_x <= clip32(zbpx);
				b_new_pos_y <= ms_end.side.bpy;
				b_new_vel_x <= ms_end.side.bvx;
				b_new_vel_y <= ms_end.side.bvy;
				saturated   <= over32(zapx) || over32(zbpx);
			end else begin
				a_new_pos_x <= clip32(wapx);
				a_new_pos_y <= clip32(wapy);
				a_new_vel_x <= clip32(wavx);
				a_new_vel_y <= clip32(wavy);
				b_new_pos_x <= clip32(wbpx);
				b_new_pos_y <= clip32(wbpy);
				b_new_vel_x <= clip32(wbvx);
				b_new_vel_y <= clip32(wbvy);
				saturated   <= over32(wapx) || over32(wapy) || over32(wavx) || over32(wavy)
				               || over32(wbpx) || over32(wbpy) || over32(wbvx)
				               || over32(wbvy);
			end
		end
	end

endmodule
`default_nettype wire

// ----- bench/elastic_disc_pair_collision_tb.sv -----
// self-checking bench for the disc pair collision block: directed pairs, then random ones
// depends on rtl/core/ecp_pkg.sv and rtl/core/elastic_disc_pair_collision.sv
`default_nettype none
module elastic_disc_pair_collision_tb;

	localparam int N_RANDOM = 2000;
	localparam int LIMIT    = 400000;
	localparam int LATENCY  = 103;
	localparam logic signed [127:0] NEAR = 128'sd16777216;

	// one input word: a disc pair
	typedef struct packed {
		logic [ecp_pkg::DATA_W-1:0] apx, apy, avx, avy;
		logic [ecp_pkg::MASS_W-1:0] ma;
		logic [ecp_pkg::DATA_W-1:0] bpx, bpy, bvx, bvy;
		logic [ecp_pkg::MASS_W-1:0] mb;
		logic [ecp_pkg::RS_W-1:0]   rs;
		logic                       en;
	} pair_t;

	// one output word: both discs after the step
	typedef struct {
		logic [ecp_pkg::DATA_W-1:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
		logic                       hit;
		logic                       sat;
	} discs_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic in_taken = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	pair_t cur = '0;
	discs_t got;

	pair_t  pending_pairs[$];
	discs_t expected_discs[$];

	int errors = 0;
	int n_total = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_hits = 0;
	int n_sats = 0;
	int cycles = 0;
	int send_idle = 0;
	int recv_idle = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit quiet;

	always #5 clk = ~clk;

	elastic_disc_pair_collision u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_pos_x(cur.apx), .a_pos_y(cur.apy), .a_vel_x(cur.avx), .a_vel_y(cur.avy),
		.a_mass(cur.ma),
		.b_pos_x(cur.bpx), .b_pos_y(cur.bpy), .b_vel_x(cur.bvx), .b_vel_y(cur.bvy),
		.b_mass(cur.mb),
		.radius_sum(cur.rs), .both_enabled(cur.en),
		.out_valid(out_valid), .out_stall(out_stall),
		.a_new_pos_x(got.apx), .a_new_pos_y(got.apy),
		.a_new_vel_x(got.avx), .a_new_vel_y(got.avy),
		.b_new_pos_x(got.bpx), .b_new_pos_y(got.bpy),
		.b_new_vel_x(got.bvx), .b_new_vel_y(got.bvy),
		.hit(got.hit), .saturated(got.sat)
	);

	// ---------------------------------------------------------------- prediction

	function automatic logic signed [127:0] wide(logic [31:0] v);
		return {{96{v[31]}}, v};
	endfunction

	// round to nearest, ties away from zero
	function automatic logic signed [127:0] div_near(logic signed [127:0] num,
			logic [127:0] den);
		logic [127:0] m;
		logic [127:0] q;
		logic [127:0] r;
		m = num < 0 ? -num : num;
		q = m / den;
		r = m % den;
		if (r >= den - r)
			q = q + 1;
		return num < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic [63:0] floor_root(logic [63:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic logic [31:0] clip(logic signed [127:0] v, inout logic sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic discs_t collide(pair_t p);
		logic signed [127:0] apx, apy, avx, avy, bpx, bpy, bvx, bvy;
		logic signed [127:0] dx, dy, d2, rs, d, diff, px, py, dot, qx, qy, m1, m2, ms;
		discs_t r;
		logic sat;
		apx = wide(p.apx); apy = wide(p.apy); avx = wide(p.avx); avy = wide(p.avy);
		bpx = wide(p.bpx); bpy = wide(p.bpy); bvx = wide(p.bvx); bvy = wide(p.bvy);
		rs = {104'd0, p.rs};
		dx = apx - bpx;
		dy = apy - bpy;
		r.hit = 1'b0;
		sat = 1'b0;
		if (p.en && dx > -NEAR && dx < NEAR && dy > -NEAR && dy < NEAR) begin
			d2 = dx * dx + dy * dy;
			if (d2 < rs * rs) begin
				r.hit = 1'b1;
				if (d2 == 0) begin
					// coincident centres: push along x only, velocities untouched
					px = (rs + 1) >>> 1;
					apx = apx + px;
					bpx = bpx - px;
				end else begin
					d = {64'd0, floor_root(d2[63:0])};
					diff = rs - d;
					px = div_near(diff * dx, 2 * d);
					py = div_near(diff * dy, 2 * d);
					dot = (avx - bvx) * dx + (avy - bvy) * dy;
					qx = div_near(dot * dx, d2);
					qy = div_near(dot * dy, d2);
					m1 = {112'd0, p.ma};
					m2 = {112'd0, p.mb};
					if (m1 + m2 == 0) begin
						m1 = 1;
						m2 = 1;
					end
					ms = m1 + m2;
					avx = avx - div_near(qx * 2 * m2, ms);
					avy = avy - div_near(qy * 2 * m2, ms);
					bvx = bvx + div_near(qx * 2 * m1, ms);
					bvy = bvy + div_near(qy * 2 * m1, ms);
					apx = apx + px; apy = apy + py;
					bpx = bpx - px; bpy = bpy - py;
				end
			end
		end
		r.apx = clip(apx, sat); r.apy = clip(apy, sat);
		r.avx = clip(avx, sat); r.avy = clip(avy, sat);
		r.bpx = clip(bpx, sat); r.bpy = clip(bpy, sat);
		r.bvx = clip(bvx, sat); r.bvy = clip(bvy, sat);
		r.sat = sat;
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report(string what, logic [31:0] g, logic [31:0] e);
		errors++;
		if (errors <= 40)
			$display("mismatch word %0d %s: got %h expected %h", n_checked, what, g, e);
	endtask

	task automatic cmp(string what, logic [31:0] g, logic [31:0] e);
		if (g !== e)
			report(what, g, e);
	endtask

	// acceptance on both sides, expected word queued before the compare
	always @(posedge clk) begin
		discs_t e;
		if (in_valid && !in_stall) begin
			expected_discs.insert(expected_discs.size(), collide(cur));
			n_accepted++;
		end
		if (out_valid && !out_stall) begin
			if (expected_discs.size() == 0) begin
				report("unexpected word", 32'd0, 32'd0);
			end else begin
				e = expected_discs.pop_front();
				cmp("a_new_pos_x", got.apx, e.apx);
				cmp("a_new_pos_y", got.apy, e.apy);
				cmp("a_new_vel_x", got.avx, e.avx);
				cmp("a_new_vel_y", got.avy, e.avy);
				cmp("b_new_pos_x", got.bpx, e.bpx);
				cmp("b_new_pos_y", got.bpy, e.bpy);
				cmp("b_new_vel_x", got.bvx, e.bvx);
				cmp("b_new_vel_y", got.bvy, e.bvy);
				cmp("hit", {31'd0, got.hit}, {31'd0, e.hit});
				cmp("saturated", {31'd0, got.sat}, {31'd0, e.sat});
				if (e.hit) n_hits++;
				if (e.sat) n_sats++;
			end
			n_checked++;
		end
	end

	// input handshake seen at the rising edge, used by the sender on the falling edge
	always @(posedge clk)
		in_taken <= in_valid && !in_stall;

	// ---------------------------------------------------------------- driving

	// no idling near the end of the run
	assign quiet = (n_accepted > n_total - 300);

	// sender: a new word only after the last one went in, valid stays up across words unless an idle gap is drawn
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (send_idle > 0) begin
				send_idle <= send_idle - 1;
				in_valid <= 1'b0;
			end else if (!quiet && in_valid && $urandom_range(7, 0) == 0) begin
				send_idle <= $urandom_range(6, 0);
				in_valid <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				cur <= pending_pairs.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off once, so the pipe fills and stalls the sender
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && n_accepted >= 400) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end
	end

	// receiver stall in random bursts
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
		end else if (recv_idle > 0) begin
			recv_idle <= recv_idle - 1;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(7, 0) == 0) begin
			recv_idle <= $urandom_range(6, 0);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	function automatic logic [31:0] offset(logic [31:0] base, int span);
		return base + ($urandom_range(2 * span, 0) - span);
	endfunction

	function automatic logic [ecp_pkg::MASS_W-1:0] any_mass();
		if ($urandom_range(99, 0) == 0)
			return '0;
		return 16'($urandom_range(65535, 1));
	endfunction

	task automatic add_pair(logic [31:0] apx, logic [31:0] apy, logic [31:0] avx,
			logic [31:0] avy, logic [15:0] ma, logic [31:0] bpx, logic [31:0] bpy,
			logic [31:0] bvx, logic [31:0] bvy, logic [15:0] mb, logic [23:0] rs,
			logic en);
		pair_t p;
		p = '{apx, apy, avx, avy, ma, bpx, bpy, bvx, bvy, mb, rs, en};
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	task automatic random_pair();
		pair_t p;
		int span;
		int kind;
		kind = $urandom_range(9, 0);
		p.apx = $urandom(); p.apy = $urandom();
		p.avx = $urandom(); p.avy = $urandom();
		p.bvx = $urandom(); p.bvy = $urandom();
		p.ma = any_mass(); p.mb = any_mass();
		p.en = ($urandom_range(15, 0) != 0);
		if (kind == 0) begin
			// noise: everything at random
			p.bpx = $urandom(); p.bpy = $urandom();
			p.rs = 24'($urandom()); p.en = 1'($urandom());
			p.ma = 16'($urandom()); p.mb = 16'($urandom());
		end else begin
			// a near pair, overlapping most of the time
			p.rs = 24'((kind < 4) ? $urandom_range(24'hffffff, 0) : $urandom_range(4096, 1));
			span = (kind == 9) ? int'(p.rs) + 64 : int'(p.rs) * 3 / 4;
			p.bpx = offset(p.apx, span);
			p.bpy = offset(p.apy, span);
			if (kind == 8) begin
				p.apx = offset(32'h0, 4096); p.apy = offset(32'h0, 4096);
				p.bpx = offset(32'h0, 4096); p.bpy = offset(32'h0, 4096);
			end
			if (kind >= 5 && kind <= 7) begin
				p.avx = offset(32'h0, 1 << 20); p.avy = offset(32'h0, 1 << 20);
				p.bvx = offset(32'h0, 1 << 20); p.bvy = offset(32'h0, 1 << 20);
			end
		end
		pending_pairs.insert(pending_pairs.size(), p);
	endtask

	initial begin
		// extremes and special cases
		add_pair(0, 0, 0, 0, 16'h0100, 0, 0, 0, 0, 16'h0100, 24'h010000, 1'b1); // coincident
		add_pair(0, 0, 5, 5, 16'h0100, 0, 0, 7, 7, 16'h0100, 24'hffffff, 1'b1); // coincident, full
		add_pair(100, 0, 1, 0, 16'h0100, 0, 0, -1, 0, 16'h0100, 24'h0, 1'b1);  // zero radius sum
		add_pair(100, 0, 1, 0, 16'h0100, 0, 0, -1, 0, 16'h0100, 24'h1000, 1'b0); // disabled
		add_pair(32'h10000, 0, 32'h20000, 0, 16'h0100, 0, 0, 0, 0, 16'h0100,
			24'h20000, 1'b1);                                              // head-on
		add_pair(32'h8000, 32'h8000, 32'h10000, -32'h10000, 0, 0, 0, 0, 0, 0,
			24'h20000, 1'b1);                                              // both masses zero
		add_pair(32'h8000, 0, 32'h10000, 0, 0, 0, 0, 0, 0, 16'hffff,
			24'h20000, 1'b1);                                              // one mass zero
		add_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'hffff,
			32'h7fff0000, 32'h7fff0000, 32'h80000000, 32'h80000000, 16'h0001,
			24'hffffff, 1'b1);                                             // saturating
		add_pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 16'h0001,
			32'h80010000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 16'hffff,
			24'hffffff, 1'b1);                                             // saturating low
		add_pair(32'h00ffffff, 0, 0, 0, 16'h0100, 0, 0, 0, 0, 16'h0100,
			24'hffffff, 1'b1);                                             // just inside near limit
		add_pair(32'h01000000, 0, 0, 0, 16'h0100, 0, 0, 0, 0, 16'h0100,
			24'hffffff, 1'b1);                                             // on near limit
		add_pair(0, 32'hff000001, 0, 0, 16'h0100, 0, 0, 0, 0, 16'h0100,
			24'hffffff, 1'b1);                                             // negative near edge
		add_pair(32'h7fffffff, 0, 0, 0, 16'h0100, 32'h80000000, 0, 0, 0, 16'h0100,
			24'hffffff, 1'b1);                                             // far wraparound
		add_pair(3, 4, 1, 2, 16'h0100, 0, 0, 3, 4, 16'h0100, 24'd5, 1'b1); // distance equals sum
		add_pair(3, 4, 1, 2, 16'h0100, 0, 0, 3, 4, 16'h0100, 24'd6, 1'b1); // just overlapping
		add_pair(1, 1, 32'hffffffff, 0, 16'hffff, 0, 0, 0, 32'hffffffff, 16'hffff,
			24'd2, 1'b1);                                                  // tiny offset
		add_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff,
			24'hffffff, 1'b1);                                             // all ones
		for (int i = 0; i < N_RANDOM; i++)
			random_pair();
		n_total = pending_pairs.size();

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (pending_pairs.size() == 0 && n_accepted == n_total);
		wait (expected_discs.size() == 0);
		repeat (2 * LATENCY) @(posedge clk);

		$display("%0d pairs checked: %0d overlapping, %0d clipped, %0d mismatches",
			n_checked, n_hits, n_sats, errors);
		if (errors == 0 && expected_discs.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/ecp_pkg.sv
rtl/core/ecp_div.sv
rtl/core/ecp_isqrt.sv
rtl/core/elastic_disc_pair_collision.sv
bench/elastic_disc_pair_collision_tb.sv
